### rtl/sorted_key_table_assert.svh
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define STK_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted key table check failed");

// next-cycle implication, checked outside reset
`define STK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted key table check failed");

`endif

### rtl/stk_pkg.sv
package stk_pkg;

  localparam int KEY_W     = 32;
  localparam int HANDLE_W  = 16;
  localparam int POS_W     = 8;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;
  // cells per first-level read group
  localparam int GROUP     = 8;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd2;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [HANDLE_W-1:0]     handle;
  } entry_t;

  typedef struct packed {
    logic ins;   // insert this cycle
    logic occ;   // cell holds a stored entry
    logic pull;  // remove: take the right neighbor's entry
  } cell_ctl_t;

endpackage

### rtl/stk_cell.sv
module stk_cell
  import stk_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    new_ent,
  input  entry_t    left_ent,
  input  entry_t    right_ent,
  input  logic      left_gt,
  output logic      gt,
  output entry_t    q
);

  assign gt = ctl.occ && ($signed(q.key) > $signed(new_ent.key));

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      // left neighbor is greater: everything here moves one place up
      if (left_gt) begin
        q <= left_ent;
      end else if (gt || !ctl.occ) begin
        q <= new_ent;
      end
    end else if (ctl.pull) begin
      q <= right_ent;
    end
  end

endmodule

### rtl/sorted_key_table.sv
// channel   dir  tdata (low bit up)                               tuser
// s_*       in   key_value[31:0] record_handle[47:32]             command[1:0]
//                position[55:48]
// m_*       out  out_key[31:0] out_handle[47:32]                  status[1:0]
//                entry_count[54:48] is_empty[55]
//
// one word accepted per cycle while s_tready is high; the row of cells
// compares and shifts in the accept cycle, and the read value passes a
// two-level registered select, held first in s1_grp and then in o_ent.
// rst clears the entry count and both valid stages; cell contents are kept.
// a stalled output holds its result, and the input stalls only once the
// select stage and the output register are both full.
module sorted_key_table
  import stk_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // key_value, record_handle, position
  input  logic [CMD_W-1:0]      s_tuser,   // command
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // out_key, out_handle, entry_count, is_empty
  output logic [STATUS_W-1:0]   m_tuser    // status
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = (CW > POS_W) ? CW : POS_W;
  localparam int OCW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int NG  = (CAPACITY + GROUP - 1) / GROUP;

  logic [CMD_W-1:0]  cmd;
  entry_t            new_ent;
  logic [POS_W-1:0]  pos;
  logic              accept;
  logic              full;
  logic [PW-1:0]     pos_e;
  logic              pos_ok;
  logic              do_ins;
  logic              do_rem;
  logic [STATUS_W-1:0] status_next;
  logic [CW-1:0]     fill_count;
  logic [CW-1:0]     fill_count_next;

  entry_t            cell_q [CAPACITY];
  logic              cell_gt [CAPACITY];
  cell_ctl_t         cell_ctl [CAPACITY];
  entry_t            grp_sel [NG];

  logic              s1_valid;
  logic [STATUS_W-1:0] s1_status;
  logic [CW-1:0]     s1_count;
  logic              s1_take;
  entry_t            s1_grp [NG];
  logic              s1_adv;
  entry_t            fold;
  logic [OCW-1:0]    cnt_o;

  logic [STATUS_W-1:0] o_status;
  entry_t            o_ent;
  logic [COUNT_W-1:0] o_count;
  logic              o_empty;

  assign cmd            = s_tuser;
  assign new_ent.key    = s_tdata[31:0];
  assign new_ent.handle = s_tdata[47:32];
  assign pos            = s_tdata[55:48];

  assign s1_adv   = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  assign full   = (fill_count == CW'(CAPACITY));
  assign pos_e  = PW'(pos);
  assign pos_ok = pos_e < PW'(fill_count);
  assign do_ins = accept && (cmd == CMD_INSERT) && !full;
  assign do_rem = accept && (cmd == CMD_REMOVE) && pos_ok;

  always_comb begin
    case (cmd)
      CMD_INSERT: status_next = full ? ST_FULL : ST_OK;
      CMD_READ, CMD_REMOVE: status_next = pos_ok ? ST_OK : ST_BAD_POS;
      default: status_next = ST_OK;
    endcase
  end

  always_comb begin
    fill_count_next = fill_count;
    if (do_ins) begin
      fill_count_next = fill_count + CW'(1);
    end else if (do_rem) begin
      fill_count_next = fill_count - CW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_gt;

    assign cell_ctl[i].ins  = do_ins;
    assign cell_ctl[i].occ  = CW'(i) < fill_count;
    assign cell_ctl[i].pull = do_rem && (PW'(i) >= pos_e);

    if (i == 0) begin : g_first
      assign left_ent = new_ent;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_ent = cell_q[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_ent = cell_q[i];
    end else begin : g_body
      assign right_ent = cell_q[i+1];
    end

    stk_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .new_ent   (new_ent),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .left_gt   (left_gt),
      .gt        (cell_gt[i]),
      .q         (cell_q[i])
    );
  end

  // first read level: pick the addressed cell inside each group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_sel[g] = '0;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (pos_e == PW'(i)) begin
        grp_sel[i / GROUP] = grp_sel[i / GROUP] | cell_q[i];
      end
    end
  end

  // second read level: only the addressed group is nonzero
  always_comb begin
    fold = '0;
    for (int g = 0; g < NG; g++) begin
      fold = fold | s1_grp[g];
    end
  end

  assign cnt_o = OCW'(s1_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      s1_valid   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (s1_adv) begin
        m_tvalid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= status_next;
      s1_count  <= fill_count_next;
      s1_take   <= ((cmd == CMD_READ) || (cmd == CMD_REMOVE)) && pos_ok;
      for (int g = 0; g < NG; g++) begin
        s1_grp[g] <= grp_sel[g];
      end
    end
    if (s1_adv && s1_valid) begin
      o_status <= s1_status;
      o_ent    <= s1_take ? fold : '0;
      o_count  <= cnt_o[COUNT_W-1:0];
      o_empty  <= (s1_count == '0);
    end
  end

  assign m_tdata = {o_empty, o_count, o_ent.handle, o_ent.key};
  assign m_tuser = o_status;

endmodule

### rtl/stk_chk.sv
`include "sorted_key_table_assert.svh"

module stk_chk
  import stk_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [STATUS_W-1:0]   m_tuser
);

  // a result waiting on the sink stays offered
  `STK_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

  // input only stalls behind a blocked output
  `STK_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready)

  // failed commands carry no entry
  `STK_ASSERT_NOW(a_fail_zero, m_tvalid && (m_tuser != ST_OK), m_tdata[47:0] == '0)

  // empty flag agrees with the count
  `STK_ASSERT_NOW(a_empty_flag, m_tvalid && m_tdata[55], m_tdata[54:48] == '0)

endmodule

bind sorted_key_table stk_chk u_stk_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### tb/tb.sv
module tb;
  import stk_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int N_ITEMS     = 1700;
  localparam int TAIL_ITEMS  = 150;
  localparam int STALL_LIMIT = 2000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] key;
    logic [HANDLE_W-1:0]     handle;
    logic [POS_W-1:0]        pos;
  } table_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] key;
    logic [HANDLE_W-1:0]     handle;
    logic [COUNT_W-1:0]      count;
    logic                    empty;
  } table_result_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX} gen_phase_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [CMD_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  table_cmd_t    pending_cmds[$];
  table_result_t expected_results[$];

  // predicted table contents
  entry_t rows[TABLE_DEPTH];
  int     row_fill = 0;

  // generator-side view of the fill level
  int gen_fill = 0;

  int errors = 0;
  int n_insert = 0, n_full = 0, n_read = 0, n_remove = 0, n_unused = 0;
  int n_bad_pos = 0, n_emptied = 0, peak_fill = 0;

  table_cmd_t cur_cmd;
  int  src_gap = 0, snk_gap = 0;
  int  src_mode_left = 0, snk_mode_left = 0;
  bit  src_busy = 0, snk_busy = 0;
  bit  tail_run = 0;
  int  stall_cycles = 0;

  sorted_key_table #(.CAPACITY(TABLE_DEPTH)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #2 clk = ~clk;

  // apply one command to the predicted table and return the expected word
  function automatic table_result_t apply_to_table(table_cmd_t c);
    table_result_t r;
    int slot;
    int i;
    int p;
    r = '0;
    p = int'(c.pos);
    case (c.cmd)
      CMD_INSERT: begin
        n_insert++;
        if (row_fill >= TABLE_DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          slot = 0;
          while (slot < row_fill && !($signed(rows[slot].key) > $signed(c.key)))
            slot++;
          for (i = row_fill; i > slot; i--)
            rows[i] = rows[i-1];
          rows[slot].key = c.key;
          rows[slot].handle = c.handle;
          row_fill++;
          if (row_fill > peak_fill)
            peak_fill = row_fill;
        end
      end
      CMD_READ, CMD_REMOVE: begin
        if (c.cmd == CMD_READ)
          n_read++;
        else
          n_remove++;
        if (p >= row_fill) begin
          r.status = ST_BAD_POS;
          n_bad_pos++;
        end else begin
          r.key = rows[p].key;
          r.handle = rows[p].handle;
          if (c.cmd == CMD_REMOVE) begin
            for (i = p; i + 1 < row_fill; i++)
              rows[i] = rows[i+1];
            row_fill--;
            if (row_fill == 0)
              n_emptied++;
          end
        end
      end
      default: n_unused++;
    endcase
    r.status = (r.status == '0) ? ST_OK : r.status;
    r.count = row_fill[COUNT_W-1:0];
    r.empty = (row_fill == 0);
    return r;
  endfunction

  task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic signed [KEY_W-1:0] key,
                          input logic [HANDLE_W-1:0] handle, input logic [POS_W-1:0] pos);
    table_cmd_t c;
    c.cmd = cmd;
    c.key = key;
    c.handle = handle;
    c.pos = pos;
    pending_cmds.push_back(c);
    if (cmd == CMD_INSERT && gen_fill < TABLE_DEPTH)
      gen_fill++;
    else if (cmd == CMD_REMOVE && int'(pos) < gen_fill)
      gen_fill--;
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 3);
    case (r)
      0, 1: return $signed(KEY_W'($urandom_range(0, 15))) - 8;  // crowded keys, many ties
      2: return $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh8000_0001;
          3: return 32'sh7fff_fffe;
          4: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    int r;
    r = $urandom_range(0, 9);
    if (gen_fill > 0 && r < 7)
      return POS_W'($urandom_range(0, gen_fill - 1));
    else if (r == 7)
      return POS_W'(gen_fill);
    else
      return POS_W'($urandom_range(0, 255));
  endfunction

  task automatic random_cmd(input int ins_pct, input int rd_pct, input int rm_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct)
      push_cmd(CMD_INSERT, pick_key(), HANDLE_W'($urandom_range(0, 65535)),
               POS_W'($urandom_range(0, 255)));
    else if (r < ins_pct + rd_pct)
      push_cmd(CMD_READ, $urandom, HANDLE_W'($urandom_range(0, 65535)), pick_pos());
    else if (r < ins_pct + rd_pct + rm_pct)
      push_cmd(CMD_REMOVE, $urandom, HANDLE_W'($urandom_range(0, 65535)), pick_pos());
    else
      push_cmd(CMD_UNUSED, $urandom, HANDLE_W'($urandom_range(0, 65535)),
               POS_W'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    gen_phase_e phase;
    int extra;
    int n;

    // directed opening
    push_cmd(CMD_READ,   0, 16'h0000, 8'd0);
    push_cmd(CMD_REMOVE, 0, 16'h0000, 8'd0);
    push_cmd(CMD_UNUSED, 32'sh5a5a_a5a5, 16'hffff, 8'hff);
    push_cmd(CMD_INSERT, 0,              16'h0000, 8'd0);
    push_cmd(CMD_INSERT, 32'sh7fff_ffff, 16'hffff, 8'd0);
    push_cmd(CMD_INSERT, 32'sh8000_0000, 16'h1234, 8'd0);
    push_cmd(CMD_INSERT, -1,             16'haaaa, 8'd0);
    push_cmd(CMD_INSERT, 0,              16'h5555, 8'd0);  // tie, goes after the older 0
    push_cmd(CMD_INSERT, 32'sh7fff_ffff, 16'h0001, 8'd0);  // tie at the top end
    push_cmd(CMD_INSERT, 32'sh8000_0000, 16'h0002, 8'd0);  // tie at the bottom end
    for (int p = 0; p < 7; p++)
      push_cmd(CMD_READ, 0, 16'h0000, POS_W'(p));
    push_cmd(CMD_READ,   0, 16'h0000, 8'd7);    // one past the last entry
    push_cmd(CMD_READ,   0, 16'h0000, 8'd255);
    push_cmd(CMD_READ,   0, 16'h0000, 8'd128);
    push_cmd(CMD_REMOVE, 0, 16'h0000, 8'd255);
    push_cmd(CMD_REMOVE, 0, 16'h0000, 8'd3);
    push_cmd(CMD_REMOVE, 0, 16'h0000, 8'd0);
    push_cmd(CMD_REMOVE, 0, 16'h0000, POS_W'(gen_fill - 1));
    push_cmd(CMD_UNUSED, -1, 16'hffff, 8'd0);

    // random part: fill to capacity, drain to empty, and mixed stretches
    phase = PH_FILL;
    while (pending_cmds.size() < N_ITEMS) begin
      case (phase)
        PH_FILL: begin
          extra = $urandom_range(3, 12);
          while (extra > 0 && pending_cmds.size() < N_ITEMS) begin
            random_cmd(75, 15, 8);
            if (gen_fill == TABLE_DEPTH)
              extra--;
          end
          phase = PH_DRAIN;
        end
        PH_DRAIN: begin
          extra = $urandom_range(2, 8);
          while (extra > 0 && pending_cmds.size() < N_ITEMS) begin
            random_cmd(20, 13, 65);
            if (gen_fill == 0)
              extra--;
          end
          phase = PH_MIX;
        end
        default: begin
          n = $urandom_range(60, 160);
          while (n > 0 && pending_cmds.size() < N_ITEMS) begin
            random_cmd(45, 25, 27);
            n--;
          end
          phase = PH_FILL;
        end
      endcase
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // sample between edges so the driver and monitor updates have settled
    while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);

    $display("ran %0d inserts (%0d refused on a full table), %0d reads,",
             n_insert, n_full, n_read);
    $display("%0d removes and %0d unused codes", n_remove, n_unused);
    $display("%0d unoccupied positions hit, table peaked at %0d entries and emptied %0d times",
             n_bad_pos, peak_fill, n_emptied);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_results.push_back(apply_to_table(cur_cmd));
      tail_run <= (pending_cmds.size() < TAIL_ITEMS);
      if (src_mode_left == 0) begin
        src_mode_left = $urandom_range(20, 150);
        src_busy = ($urandom_range(0, 2) != 0);
      end
      src_mode_left--;
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          s_tdata <= {cur_cmd.pos, cur_cmd.handle, cur_cmd.key};
          s_tuser <= cur_cmd.cmd;
          s_tvalid <= 1'b1;
          if (src_busy && !tail_run && $urandom_range(0, 5) == 0)
            src_gap = $urandom_range(1, 8);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    table_result_t got;
    table_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = m_tuser;
        got.key = m_tdata[31:0];
        got.handle = m_tdata[47:32];
        got.count = m_tdata[54:48];
        got.empty = m_tdata[55];
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected: status %0d key %0d handle %h",
                   $time, got.status, got.key, got.handle);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          end
          if (got.key !== want.key) begin
            errors++;
            $display("%0t: out_key expected %0d actual %0d", $time, want.key, got.key);
          end
          if (got.handle !== want.handle) begin
            errors++;
            $display("%0t: out_handle expected %h actual %h", $time, want.handle, got.handle);
          end
          if (got.count !== want.count) begin
            errors++;
            $display("%0t: entry_count expected %0d actual %0d", $time, want.count, got.count);
          end
          if (got.empty !== want.empty) begin
            errors++;
            $display("%0t: is_empty expected %0d actual %0d", $time, want.empty, got.empty);
          end
        end
      end
      if (snk_mode_left == 0) begin
        snk_mode_left = $urandom_range(20, 150);
        snk_busy = ($urandom_range(0, 2) != 0);
      end
      snk_mode_left--;
      if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (snk_busy && !tail_run && $urandom_range(0, 5) == 0)
          snk_gap = $urandom_range(1, 8);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

### sim.f
+incdir+rtl
rtl/stk_pkg.sv
rtl/stk_cell.sv
rtl/sorted_key_table.sv
rtl/stk_chk.sv
tb/tb.sv
